// File: rtl/core/rpc_pkg.sv
// Shared constants for the relative polar converter: field widths, CORDIC
// formats, arctangent table and configuration register indexes.
// No dependencies.
package rpc_pkg;

  localparam int COORD_W     = 12;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int DIST_W      = 13;
  localparam int ANGLE_W     = 15;
  localparam int CFG_IDX_W   = 2;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN   = 24;
  localparam int FRAC_BITS   = 16;
  localparam int XY_W        = 32;
  localparam int Z_W         = 22;
  localparam int ANGLE_EXTRA = 7;
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = (XY_W - 1) + GAIN_W;

  localparam logic [COORD_W-1:0] CENTER_RESET = COORD_W'(2048);
  localparam logic [GAIN_W-1:0]  GAIN_Q16     = GAIN_W'(39797);
  localparam logic [DIST_W-1:0]  DIST_MAX     = {DIST_W{1'b1}};

  localparam logic signed [ANGLE_W:0] HALF_PI_UNITS = (ANGLE_W+1)'(4096);
  localparam logic signed [ANGLE_W:0] PI_UNITS      = (ANGLE_W+1)'(8192);
  localparam logic signed [ANGLE_W:0] ANGLE_CLAMP   = HALF_PI_UNITS - (ANGLE_W+1)'(1);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);

  // round(atan(2^-i) * 2^20 / pi)
  localparam logic signed [Z_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    Z_W'(262144), Z_W'(154753), Z_W'(81767), Z_W'(41506),
    Z_W'(20835),  Z_W'(10427),  Z_W'(5215),  Z_W'(2608),
    Z_W'(1304),   Z_W'(652),    Z_W'(326),   Z_W'(163),
    Z_W'(81),     Z_W'(41),     Z_W'(20),    Z_W'(10),
    Z_W'(5),      Z_W'(3),      Z_W'(1),     Z_W'(1),
    Z_W'(0),      Z_W'(0),      Z_W'(0),     Z_W'(0)
  };

endpackage

// File: rtl/core/relative_polar_converter.sv
// Relative polar converter top level: distance and angle of a point from a
// configured center by a pipelined CORDIC in vectoring mode.
// Depends on rpc_pkg.
//
//   channel  ports                                   request carries
//   in       in_valid/in_ready                       in_point_x, in_point_y
//   out      out_valid/out_ready                     out_distance, out_angle, out_valid_res
//   cfg      cfg_valid/cfg_ready                     cfg_index, cfg_wdata
//
// One request enters per cycle while no waiting result stalls the pipeline; the
// stages are one input stage, one register per CORDIC stage, one stage for the
// angle fix-up and gain multiply, one output register.
// Reset clears all valid bits and sets both centers to 2048.
// A waiting result freezes the whole pipeline; nothing is lost or repeated.
// cfg_ready is always high.
module relative_polar_converter #(
  parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rpc_pkg::COORD_W-1:0]         in_point_x,
  input  logic [rpc_pkg::COORD_W-1:0]         in_point_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpc_pkg::DIST_W-1:0]          out_distance,
  output logic signed [rpc_pkg::ANGLE_W-1:0]  out_angle,
  output logic                                out_valid_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpc_pkg::COORD_W-1:0]         cfg_wdata
);
  import rpc_pkg::*;

  logic [COORD_W-1:0] center_x_r, center_y_r;
  logic               adv;

  logic                     v_r    [0:CORDIC_STAGES];
  logic                     neg_r  [0:CORDIC_STAGES];
  logic                     zero_r [0:CORDIC_STAGES];
  logic signed [XY_W-1:0]   x_r    [0:CORDIC_STAGES];
  logic signed [XY_W-1:0]   y_r    [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]    z_r    [0:CORDIC_STAGES];

  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic [COORD_W-1:0]       adx_nxt;

  logic                     p_v_r, p_zero_r;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic signed [ANGLE_W-1:0] ang_r, ang_nxt;
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [ANGLE_W:0]  a_full, a_clamp, ang_full;

  logic                     out_valid_r, out_valid_res_r;
  logic [DIST_W-1:0]        out_distance_r, dist_nxt;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic [PROD_W:0]          dist_sum;
  logic [PROD_W-32:0]       dist_q;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_RESET;
      center_y_r <= CENTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx_nxt  = $signed({1'b0, in_point_x}) - $signed({1'b0, center_x_r});
    dy_nxt  = $signed({1'b0, in_point_y}) - $signed({1'b0, center_y_r});
    adx_nxt = dx_nxt[DIFF_W-1] ? COORD_W'(-dx_nxt) : dx_nxt[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r[0]  <= dx_nxt[DIFF_W-1];
      zero_r[0] <= (dx_nxt == '0) && (dy_nxt == '0);
      x_r[0]    <= $signed({{(XY_W-COORD_W-FRAC_BITS){1'b0}}, adx_nxt, {FRAC_BITS{1'b0}}});
      y_r[0]    <= $signed({{(XY_W-DIFF_W-FRAC_BITS){dy_nxt[DIFF_W-1]}}, dy_nxt,
                            {FRAC_BITS{1'b0}}});
      z_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [XY_W-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    always_comb begin
      xs = x_r[k] >>> k;
      ys = y_r[k] >>> k;
      if (!y_r[k][XY_W-1]) begin
        x_nxt = x_r[k] + ys;
        y_nxt = y_r[k] - xs;
        z_nxt = z_r[k] + ATAN_TAB[k];
      end else begin
        x_nxt = x_r[k] - ys;
        y_nxt = y_r[k] + xs;
        z_nxt = z_r[k] - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        x_r[k+1]    <= x_nxt;
        y_r[k+1]    <= y_nxt;
        z_r[k+1]    <= z_nxt;
      end
    end
  end

  always_comb begin
    z_rnd  = z_r[CORDIC_STAGES] + Z_W'(1 << (ANGLE_EXTRA - 1));
    a_full = (ANGLE_W+1)'(z_rnd >>> ANGLE_EXTRA);
    a_clamp = a_full;
    if (a_full > ANGLE_CLAMP)
      a_clamp = ANGLE_CLAMP;
    if (a_full < -ANGLE_CLAMP)
      a_clamp = -ANGLE_CLAMP;
    ang_full = neg_r[CORDIC_STAGES] ? (PI_UNITS - a_clamp) : a_full;
    ang_nxt  = ang_full[ANGLE_W-1:0];
    if (x_r[CORDIC_STAGES][XY_W-1])
      prod_nxt = '0;
    else
      prod_nxt = PROD_W'(x_r[CORDIC_STAGES][XY_W-2:0]) * PROD_W'(GAIN_Q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= v_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_zero_r <= zero_r[CORDIC_STAGES];
      prod_r   <= prod_nxt;
      ang_r    <= ang_nxt;
    end
  end

  always_comb begin
    dist_sum = {1'b0, prod_r} + (PROD_W+1)'(64'd1 << 31);
    dist_q   = dist_sum[PROD_W:32];
    dist_nxt = (dist_q > (PROD_W-31)'(DIST_MAX)) ? DIST_MAX : dist_q[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_valid_res_r <= !p_zero_r;
      out_distance_r  <= p_zero_r ? '0 : dist_nxt;
      out_angle_r     <= p_zero_r ? '0 : ang_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_valid_res_r;
  assign out_distance  = out_distance_r;
  assign out_angle     = out_angle_r;

`ifndef NO_ASSERTIONS
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_distance == '0 && out_angle == '0)
    else $error("degenerate point gives non-zero result");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      out_angle <= $signed(ANGLE_W'(12287)) && out_angle >= $signed(ANGLE_W'(-8192)))
    else $error("angle outside its range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_angle))
    else $error("waiting result changed");
`endif

endmodule
